// File: src/interval_union_longest_run_gap_core_macros.svh
// Assertion macros shared by the interval union checker.
`ifndef INTERVAL_UNION_LONGEST_RUN_GAP_CORE_MACROS_SVH
`define INTERVAL_UNION_LONGEST_RUN_GAP_CORE_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define IULRG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define IULRG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/iulrg_pkg.sv
// Shared types and constants of the interval union core.
package iulrg_pkg;

    localparam int MAX_INTERVALS = 256;
    localparam int TIME_BITS     = 24;

    typedef logic [TIME_BITS-1:0] time_t;

    // One stored interval of the sorting chain.
    typedef struct packed {
        logic  valid;
        time_t start;
        time_t fin;
    } entry_t;

    // Chain control for one cycle.
    typedef struct packed {
        logic insert;
        logic shift;
    } chain_ctl_t;

    // Figures produced by the merge walk.
    typedef struct packed {
        time_t covered;
        time_t gap;
    } merge_res_t;

endpackage

// File: src/iulrg_cell.sv
// One cell of the insertion chain: holds a single interval.
module iulrg_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  iulrg_pkg::chain_ctl_t ctl_i,
    input  iulrg_pkg::entry_t   new_i,
    input  iulrg_pkg::entry_t   prev_i,
    input  logic                prev_take_i,
    input  iulrg_pkg::entry_t   nbr_i,
    output logic                take_o,
    output iulrg_pkg::entry_t   ent_o
);

    logic                valid_reg;
    iulrg_pkg::time_t    start_reg;
    iulrg_pkg::time_t    fin_reg;
    iulrg_pkg::entry_t   ent_next;

    assign ent_o = '{valid: valid_reg, start: start_reg, fin: fin_reg};

    // A free cell or one whose start lies above the new start gives way, so
    // equal starts keep their arrival order.
    assign take_o = !valid_reg || (start_reg > new_i.start);

    always_comb begin
        ent_next = ent_o;
        if (ctl_i.shift) begin
            ent_next = nbr_i;
        end else if (ctl_i.insert && take_o) begin
            ent_next = prev_take_i ? prev_i : new_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= ent_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= ent_next.start;
        fin_reg   <= ent_next.fin;
    end

endmodule

// File: src/iulrg_chain.sv
// Row of insertion cells that keeps the intervals sorted by start.
module iulrg_chain (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  iulrg_pkg::chain_ctl_t ctl_i,
    input  iulrg_pkg::entry_t     new_i,
    output iulrg_pkg::entry_t     head_o,
    output logic                  full_o
);

    iulrg_pkg::entry_t cell_ent [iulrg_pkg::MAX_INTERVALS];
    logic              cell_take [iulrg_pkg::MAX_INTERVALS];

    for (genvar i = 0; i < iulrg_pkg::MAX_INTERVALS; i++) begin : g_cell
        iulrg_pkg::entry_t prev_ent;
        iulrg_pkg::entry_t nbr_ent;
        logic              prev_take;

        if (i == 0) begin : g_first
            assign prev_ent  = '0;
            assign prev_take = 1'b0;
        end else begin : g_mid
            assign prev_ent  = cell_ent[i-1];
            assign prev_take = cell_take[i-1];
        end

        if (i == iulrg_pkg::MAX_INTERVALS - 1) begin : g_tail
            assign nbr_ent = '0;
        end else begin : g_body
            assign nbr_ent = cell_ent[i+1];
        end

        iulrg_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl_i       (ctl_i),
            .new_i       (new_i),
            .prev_i      (prev_ent),
            .prev_take_i (prev_take),
            .nbr_i       (nbr_ent),
            .take_o      (cell_take[i]),
            .ent_o       (cell_ent[i])
        );
    end

    assign head_o = cell_ent[0];
    assign full_o = cell_ent[iulrg_pkg::MAX_INTERVALS-1].valid;

endmodule

// File: src/iulrg_merge.sv
// Merge walker: folds sorted intervals into runs and tracks the best span and gap.
module iulrg_merge (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_i,
    input  logic                   clear_i,
    input  iulrg_pkg::entry_t      head_i,
    output iulrg_pkg::merge_res_t  res_o
);

    logic             empty_reg;
    iulrg_pkg::time_t run_head_reg;
    iulrg_pkg::time_t run_tail_reg;
    iulrg_pkg::time_t best_cov_reg;
    iulrg_pkg::time_t best_gap_reg;

    iulrg_pkg::time_t run_len;
    iulrg_pkg::time_t gap_len;

    assign run_len = run_tail_reg - run_head_reg;
    assign gap_len = head_i.start - run_tail_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_reg    <= 1'b1;
            best_cov_reg <= '0;
            best_gap_reg <= '0;
        end else if (clear_i) begin
            empty_reg    <= 1'b1;
            best_cov_reg <= '0;
            best_gap_reg <= '0;
        end else if (step_i) begin
            empty_reg <= 1'b0;
            if (!empty_reg && (head_i.start > run_tail_reg)) begin
                if (run_len > best_cov_reg) begin
                    best_cov_reg <= run_len;
                end
                if (gap_len > best_gap_reg) begin
                    best_gap_reg <= gap_len;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_i) begin
            if (empty_reg || (head_i.start > run_tail_reg)) begin
                run_head_reg <= head_i.start;
                run_tail_reg <= head_i.fin;
            end else if (head_i.fin > run_tail_reg) begin
                run_tail_reg <= head_i.fin;
            end
        end
    end

    // The open run is closed here, when the result is taken.
    always_comb begin
        res_o.gap = best_gap_reg;
        if (empty_reg) begin
            res_o.covered = '0;
        end else if (run_len > best_cov_reg) begin
            res_o.covered = run_len;
        end else begin
            res_o.covered = best_cov_reg;
        end
    end

endmodule

// File: src/interval_union_longest_run_gap_core.sv
// Top level of the interval union core: longest merged run and longest gap.
// Intervals arrive one per request and are taken at one per clock while a set
// is loading; each enters a chain of 256 cells that keeps them sorted by start,
// with equal starts kept in arrival order, and an interval whose end lies below
// its start is stored as zero length. Once the chain is full, further
// intervals of the set are dropped and the result reports capacity_overflow.
// The request marked last closes the set: input stops being accepted while the
// merge walker shifts the chain out one interval per clock, after which the
// result sits in an output register until taken. The chain's shift-out is
// what sets the walk length. A new set may begin loading while the previous
// result still waits on m_ready; only the end of the next walk waits for it.
module interval_union_longest_run_gap_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [23:0]                 s_interval_start,
    input  logic [23:0]                 s_interval_end,
    input  logic                        s_is_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [23:0]                 m_longest_covered,
    output logic [23:0]                 m_longest_gap,
    output logic                        m_capacity_overflow
);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic                    dropped_reg;
    logic                    m_valid_reg;
    logic [23:0]             covered_reg;
    logic [23:0]             gap_reg;
    logic                    overflow_reg;

    logic                    s_accept;
    logic                    finish;
    logic                    full;
    iulrg_pkg::entry_t       head;
    iulrg_pkg::entry_t       new_ent;
    iulrg_pkg::chain_ctl_t   ctl;
    iulrg_pkg::merge_res_t   res;

    assign s_ready  = (state_reg == ST_LOAD);
    assign s_accept = s_valid && s_ready;

    // Clamp a reversed interval to zero length at its start.
    always_comb begin
        new_ent.valid = 1'b1;
        new_ent.start = s_interval_start;
        new_ent.fin   = (s_interval_end < s_interval_start) ? s_interval_start
                                                            : s_interval_end;
    end

    // During the walk the chain moves toward its head one cell per clock and
    // the walker eats the head; an empty head means the set is used up.
    assign ctl.insert = s_accept && !full;
    assign ctl.shift  = (state_reg == ST_WALK) && head.valid;
    assign finish     = (state_reg == ST_WALK) && !head.valid
                        && (!m_valid_reg || m_ready);

    iulrg_chain u_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (ctl),
        .new_i   (new_ent),
        .head_o  (head),
        .full_o  (full)
    );

    iulrg_merge u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (ctl.shift),
        .clear_i (finish),
        .head_i  (head),
        .res_o   (res)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept && s_is_last) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (finish) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                dropped_reg <= 1'b0;
            end else if (s_accept && full) begin
                dropped_reg <= 1'b1;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            covered_reg  <= res.covered;
            gap_reg      <= res.gap;
            overflow_reg <= dropped_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_longest_covered   = covered_reg;
    assign m_longest_gap       = gap_reg;
    assign m_capacity_overflow = overflow_reg;

endmodule

// File: src/iulrg_checker.sv
// Port-level checker of the interval union core and its bind.
`include "interval_union_longest_run_gap_core_macros.svh"

module iulrg_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_is_last,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [23:0] m_longest_covered,
    input  logic [23:0] m_longest_gap,
    input  logic        m_capacity_overflow
);

    // A stalled result keeps its value.
    `IULRG_ASSERT(a_result_held, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_longest_covered) && $stable(m_longest_gap) && $stable(m_capacity_overflow)), "result changed while stalled")

    // Closing a set stops input for the walk.
    `IULRG_ASSERT(a_last_stops_input, aclk, aresetn, (s_valid && s_ready && s_is_last) |=> !s_ready, "input still open after last request")

    // A result only appears at the end of a walk.
    `IULRG_ASSERT(a_result_after_walk, aclk, aresetn, $rose(m_valid) |-> !$past(s_ready), "result raised without a walk")

    // Reset leaves no result pending.
    `IULRG_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result pending after reset")

endmodule

bind interval_union_longest_run_gap_core iulrg_checker u_iulrg_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .s_is_last           (s_is_last),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_longest_covered   (m_longest_covered),
    .m_longest_gap       (m_longest_gap),
    .m_capacity_overflow (m_capacity_overflow)
);

// File: dv/tb_interval_union_longest_run_gap_core.sv
// Self-checking testbench for the interval union core with a built-in predictor.
`timescale 1ns / 1ps

module tb_interval_union_longest_run_gap_core;

    typedef iulrg_pkg::time_t time_t;

    // Cycles with no handshake on either channel before the run is declared hung.
    // The slowest legitimate stretch is a full merge walk followed by the longest
    // result stall and the longest request gap, so this leaves ample margin.
    localparam int IDLE_LIMIT   = 3000;
    // Quiet cycles after the last expected result, long enough to expose any stray
    // result from a walk that should never have started.
    localparam int DRAIN_CYCLES = 600;
    localparam int MAX_WAIT     = 17;
    localparam int ITEM_TARGET  = 1050;
    localparam int REPORT_LIMIT = 10;
    localparam time_t TIME_MAX  = {iulrg_pkg::TIME_BITS{1'b1}};

    // Shapes of random interval sets. Clustered and grid sets overlap and touch a
    // lot, so they exercise merging; spread sets make long gaps; noise sets draw
    // both ends at random, which often puts the end below the start.
    typedef enum int {
        SET_CLUSTER,
        SET_GRID,
        SET_SPREAD,
        SET_NOISE
    } set_style_t;

    // One pending request together with the idle cycles that precede it.
    typedef struct {
        time_t       t_start;
        time_t       t_stop;
        logic        closes;
        int unsigned gap;
    } interval_req_t;

    // The figures one closed set should produce.
    typedef struct {
        time_t covered;
        time_t gap;
        logic  overflow;
    } span_summary_t;

    logic  aclk;
    logic  aresetn             = 1'b0;
    logic  s_valid             = 1'b0;
    logic  s_ready;
    time_t s_interval_start    = '0;
    time_t s_interval_end      = '0;
    logic  s_is_last           = 1'b0;
    logic  m_valid;
    logic  m_ready             = 1'b0;
    time_t m_longest_covered;
    time_t m_longest_gap;
    logic  m_capacity_overflow;

    interval_req_t interval_queue[$];
    span_summary_t expected_spans[$];

    // Predictor state: the sorted store as the block should hold it.
    time_t held_starts [iulrg_pkg::MAX_INTERVALS];
    time_t held_ends   [iulrg_pkg::MAX_INTERVALS];
    int    held_count   = 0;
    logic  held_dropped = 1'b0;

    int    mismatches   = 0;
    int    idle_cycles  = 0;
    int    queued_items = 0;
    int    send_wait    = 0;
    int    rx_hold      = 0;
    bit    rx_calm      = 1'b0;

    interval_union_longest_run_gap_core i_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_interval_start    (s_interval_start),
        .s_interval_end      (s_interval_end),
        .s_is_last           (s_is_last),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_longest_covered   (m_longest_covered),
        .m_longest_gap       (m_longest_gap),
        .m_capacity_overflow (m_capacity_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Takes one accepted request into the predicted store. An end below its start
    // shrinks the interval to zero length. With the store full the interval is
    // dropped and the set is flagged, even when it is the closing request. A
    // closing request then walks the sorted store: an interval whose start is at
    // or below the current tail joins the run, so touching intervals merge, and
    // the last run is counted like the others. The store is emptied afterwards.
    task automatic absorb_interval(input time_t t_start, input time_t t_stop,
                                   input logic closes);
        int            pos;
        int            idx;
        time_t         stop_eff;
        time_t         head;
        time_t         tail;
        span_summary_t summary;
        stop_eff = (t_stop < t_start) ? t_start : t_stop;
        if (held_count >= iulrg_pkg::MAX_INTERVALS) begin
            held_dropped = 1'b1;
        end else begin
            // Equal starts stay in arrival order: only strictly larger ones move up.
            pos = held_count;
            while (pos > 0 && held_starts[pos-1] > t_start) begin
                held_starts[pos] = held_starts[pos-1];
                held_ends[pos]   = held_ends[pos-1];
                pos--;
            end
            held_starts[pos] = t_start;
            held_ends[pos]   = stop_eff;
            held_count++;
        end
        if (closes) begin
            summary.covered  = '0;
            summary.gap      = '0;
            summary.overflow = held_dropped;
            if (held_count > 0) begin
                head = held_starts[0];
                tail = held_ends[0];
                for (idx = 1; idx < held_count; idx++) begin
                    if (held_starts[idx] <= tail) begin
                        if (held_ends[idx] > tail) begin
                            tail = held_ends[idx];
                        end
                    end else begin
                        if (tail - head > summary.covered) begin
                            summary.covered = tail - head;
                        end
                        if (held_starts[idx] - tail > summary.gap) begin
                            summary.gap = held_starts[idx] - tail;
                        end
                        head = held_starts[idx];
                        tail = held_ends[idx];
                    end
                end
                if (tail - head > summary.covered) begin
                    summary.covered = tail - head;
                end
            end
            expected_spans.push_back(summary);
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic compare_field(input string label, input time_t got, input time_t want);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, label, want,
                         got);
            end
        end
    endtask

    function automatic time_t clip(input longint unsigned value);
        return (value > TIME_MAX) ? TIME_MAX : time_t'(value);
    endfunction

    // Queues one request. A calm request is presented without any idle cycles so
    // that some sets load back to back.
    task automatic queue_interval(input time_t t_start, input time_t t_stop,
                                  input logic closes, input bit calm);
        interval_req_t req;
        req.t_start = t_start;
        req.t_stop  = t_stop;
        req.closes  = closes;
        req.gap     = calm ? 0 : $urandom_range(0, MAX_WAIT);
        interval_queue.push_back(req);
        queued_items++;
    endtask

    // Queues a whole set of n intervals of one shape, the last request closing it.
    task automatic queue_random_set(input int n, input set_style_t style);
        int              idx;
        bit              calm;
        longint unsigned base;
        longint unsigned lo;
        longint unsigned hi;
        calm = ($urandom_range(0, 3) == 0);
        base = $urandom_range(0, TIME_MAX);
        for (idx = 0; idx < n; idx++) begin
            case (style)
                SET_CLUSTER: begin
                    lo = clip(base + $urandom_range(0, 40 * n));
                    hi = clip(lo + $urandom_range(0, 60));
                    // Now and then an end below its start inside an otherwise sane set.
                    if ($urandom_range(0, 9) == 0 && lo > 0) begin
                        hi = lo - 1;
                    end
                end
                SET_GRID: begin
                    lo = clip(base + 16 * $urandom_range(0, 2 * n));
                    hi = clip(lo + 16 * $urandom_range(0, 2));
                end
                SET_SPREAD: begin
                    lo = $urandom_range(0, TIME_MAX);
                    hi = clip(lo + $urandom_range(0, (1 << $urandom_range(0, 23))));
                end
                default: begin
                    lo = $urandom_range(0, TIME_MAX);
                    hi = $urandom_range(0, TIME_MAX);
                end
            endcase
            queue_interval(time_t'(lo), time_t'(hi), idx == n - 1, calm);
        end
    endtask

    function automatic set_style_t pick_style();
        int unsigned roll;
        roll = $urandom_range(0, 7);
        if (roll < 3) begin
            return SET_CLUSTER;
        end else if (roll < 5) begin
            return SET_GRID;
        end else if (roll < 7) begin
            return SET_SPREAD;
        end
        return SET_NOISE;
    endfunction

    // Request driver. A new request is put on the bus only when the slot is free,
    // that is when nothing is pending or the pending request is taken at this
    // edge, after the idle cycles drawn for it. s_valid is assigned once per edge,
    // so back-to-back requests keep it high without a glitch.
    always @(posedge aclk) begin : drive_requests
        interval_req_t req;
        if (!aresetn) begin
            s_valid          <= 1'b0;
            s_interval_start <= '0;
            s_interval_end   <= '0;
            s_is_last        <= 1'b0;
            send_wait        <= 0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_interval(s_interval_start, s_interval_end, s_is_last);
            end
            if (!s_valid || s_ready) begin
                if (interval_queue.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (send_wait < interval_queue[0].gap) begin
                    s_valid   <= 1'b0;
                    send_wait <= send_wait + 1;
                end else begin
                    req = interval_queue.pop_front();
                    s_valid          <= 1'b1;
                    s_interval_start <= req.t_start;
                    s_interval_end   <= req.t_stop;
                    s_is_last        <= req.closes;
                    send_wait        <= 0;
                end
            end
        end
    end

    // Result monitor. After each result the receiver draws a stall, counted over
    // cycles in which a result is offered, before it raises m_ready again. Calm
    // stretches with m_ready held high come and go at random.
    always @(posedge aclk) begin : collect_results
        span_summary_t want;
        int            stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_hold <= $urandom_range(0, MAX_WAIT);
        end else if (m_valid && m_ready) begin
            if (expected_spans.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: unexpected result covered %0h gap %0h overflow %0b",
                             $realtime, m_longest_covered, m_longest_gap,
                             m_capacity_overflow);
                end
            end else begin
                want = expected_spans.pop_front();
                compare_field("longest_covered", m_longest_covered, want.covered);
                compare_field("longest_gap", m_longest_gap, want.gap);
                compare_field("capacity_overflow", time_t'(m_capacity_overflow),
                              time_t'(want.overflow));
            end
            if ($urandom_range(0, 5) == 0) begin
                rx_calm <= !rx_calm;
            end
            stall = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            rx_hold <= stall;
            m_ready <= (stall == 0);
        end else if (!m_ready) begin
            if (rx_hold == 0) begin
                m_ready <= 1'b1;
            end else if (m_valid) begin
                rx_hold <= rx_hold - 1;
            end
        end
    end

    // Watchdog: any stretch without a handshake on either channel that outlasts
    // the slowest correct behavior means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        int n;
        int set_index;

        // Directed sets. Single intervals at the bottom and top of the time range,
        // and one that covers all of it.
        queue_interval(24'h000000, 24'h000000, 1'b1, 1'b0);
        queue_interval(TIME_MAX, TIME_MAX, 1'b1, 1'b0);
        queue_interval(24'h000000, TIME_MAX, 1'b1, 1'b0);
        // An end below its start counts as a zero-length interval at the start.
        queue_interval(24'd100, 24'd50, 1'b0, 1'b0);
        queue_interval(24'd10, 24'd20, 1'b1, 1'b0);
        // Touching intervals arriving out of order merge into one run.
        queue_interval(24'd30, 24'd40, 1'b0, 1'b1);
        queue_interval(24'd10, 24'd30, 1'b0, 1'b1);
        queue_interval(24'd40, 24'd45, 1'b1, 1'b1);
        // Equal starts and a reversed arrival order.
        queue_interval(24'd500, 24'd600, 1'b0, 1'b0);
        queue_interval(24'd200, 24'd210, 1'b0, 1'b0);
        queue_interval(24'd500, 24'd505, 1'b0, 1'b0);
        queue_interval(24'd0, 24'd5, 1'b0, 1'b0);
        queue_interval(24'd200, 24'd300, 1'b1, 1'b0);
        // An interval contained in another, then a separate run after a gap.
        queue_interval(24'd1000, 24'd2000, 1'b0, 1'b1);
        queue_interval(24'd1100, 24'd1200, 1'b0, 1'b1);
        queue_interval(24'd2500, 24'd2600, 1'b1, 1'b1);
        // Values either side of the midpoint and a maximal start with a zero end.
        queue_interval(TIME_MAX, 24'h000000, 1'b0, 1'b0);
        queue_interval(24'h000000, 24'h000001, 1'b0, 1'b0);
        queue_interval(24'h800000, 24'h7FFFFF, 1'b0, 1'b0);
        queue_interval(24'h7FFFFF, 24'h800000, 1'b1, 1'b0);

        // Random sets. Two of them test capacity: one fills the store exactly, a
        // later one overruns it so that the tail of the set, closing request included,
        // is dropped and flagged.
        set_index = 0;
        while (queued_items < ITEM_TARGET) begin
            if (set_index == 6) begin
                n = iulrg_pkg::MAX_INTERVALS;
            end else if (set_index == 18) begin
                n = iulrg_pkg::MAX_INTERVALS + $urandom_range(1, 6);
            end else if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(13, 40);
            end else begin
                n = $urandom_range(1, 12);
            end
            queue_random_set(n, pick_style());
            set_index++;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Every request taken, then every result in; the watchdog bounds both waits.
        while (interval_queue.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_spans.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_spans.size() != 0) begin
            mismatches += expected_spans.size();
        end
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/iulrg_pkg.sv
src/iulrg_cell.sv
src/iulrg_chain.sv
src/iulrg_merge.sv
src/interval_union_longest_run_gap_core.sv
src/iulrg_checker.sv
dv/tb_interval_union_longest_run_gap_core.sv
